// File: hw/rtl/mcp_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// mcp_pkg
// Shared constants, register codes and the exp table series for the payoff core.
// -----------------------------------------------------------------------------
package mcp_pkg;

  localparam int unsigned ExpTableEntriesDef = 64;

  localparam logic [63:0] Log2eQ30 = 64'd1549082005;
  localparam logic [63:0] Ln2Q30   = 64'd744261118;
  localparam logic [31:0] TwoQ30   = 32'h8000_0000;
  localparam logic [31:0] Max32    = 32'hFFFF_FFFF;
  localparam int          XLimit   = 1073741824;

  localparam int unsigned AddrW = 5;

  typedef enum logic [2:0] {
    RegSpot     = 3'd0,
    RegStrike   = 3'd1,
    RegDrift    = 3'd2,
    RegSpread   = 3'd3,
    RegDiscount = 3'd4
  } reg_idx_e;

  // e^a in Q2.30 from a 25-term truncated Taylor series, a in Q2.30
  function automatic logic [31:0] exp_taylor(logic [63:0] a);
    logic [63:0] term;
    logic [63:0] sum;
    term = 64'd1073741824;
    sum  = term;
    term = ((term * a) >> 30) / 1;  sum = sum + term;
    term = ((term * a) >> 30) / 2;  sum = sum + term;
    term = ((term * a) >> 30) / 3;  sum = sum + term;
    term = ((term * a) >> 30) / 4;  sum = sum + term;
    term = ((term * a) >> 30) / 5;  sum = sum + term;
    term = ((term * a) >> 30) / 6;  sum = sum + term;
    term = ((term * a) >> 30) / 7;  sum = sum + term;
    term = ((term * a) >> 30) / 8;  sum = sum + term;
    term = ((term * a) >> 30) / 9;  sum = sum + term;
    term = ((term * a) >> 30) / 10; sum = sum + term;
    term = ((term * a) >> 30) / 11; sum = sum + term;
    term = ((term * a) >> 30) / 12; sum = sum + term;
    term = ((term * a) >> 30) / 13; sum = sum + term;
    term = ((term * a) >> 30) / 14; sum = sum + term;
    term = ((term * a) >> 30) / 15; sum = sum + term;
    term = ((term * a) >> 30) / 16; sum = sum + term;
    term = ((term * a) >> 30) / 17; sum = sum + term;
    term = ((term * a) >> 30) / 18; sum = sum + term;
    term = ((term * a) >> 30) / 19; sum = sum + term;
    term = ((term * a) >> 30) / 20; sum = sum + term;
    term = ((term * a) >> 30) / 21; sum = sum + term;
    term = ((term * a) >> 30) / 22; sum = sum + term;
    term = ((term * a) >> 30) / 23; sum = sum + term;
    term = ((term * a) >> 30) / 24; sum = sum + term;
    return sum[31:0];
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/mcp_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// mcp_if
// Request and response channels of the payoff core.
// -----------------------------------------------------------------------------
interface mcp_req_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] gauss_sample;
  modport source (output valid, output gauss_sample, input ready);
  modport sink   (input valid, input gauss_sample, output ready);
endinterface

interface mcp_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] payoff;
  logic        saturated;
  modport source (output valid, output payoff, output saturated, input ready);
  modport sink   (input valid, input payoff, input saturated, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/mcp_exp.sv
`default_nettype none
// -----------------------------------------------------------------------------
// mcp_exp
// Three-stage 2^(x*log2 e): integer exponent plus table-interpolated mantissa.
// -----------------------------------------------------------------------------
module mcp_exp #(
  parameter int unsigned EXP_TABLE_ENTRIES = mcp_pkg::ExpTableEntriesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic signed [31:0] x_i,
  output logic                    valid_o,
  output logic [31:0]             mant_o,
  output logic signed [7:0]       exp_o
);
  import mcp_pkg::*;

  localparam int unsigned IdxW = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int unsigned TW   = 24 + IdxW;

  logic [31:0] tbl [EXP_TABLE_ENTRIES + 1];

  for (genvar g = 0; g <= EXP_TABLE_ENTRIES; g++) begin : g_tbl
    localparam logic [63:0] ArgQ30 = (64'(g) * Ln2Q30) / 64'(EXP_TABLE_ENTRIES);
    if (g == EXP_TABLE_ENTRIES) begin : g_top
      assign tbl[g] = TwoQ30;
    end else begin : g_ent
      assign tbl[g] = exp_taylor(ArgQ30);
    end
  end

  logic [2:0]        v_q;
  logic signed [31:0] y_q;
  logic signed [63:0] yprod;
  logic [31:0]       lo_q, hi_q, lo_d, hi_d;
  logic [23:0]       w_q;
  logic signed [7:0] n1_q, n2_q;
  logic [TW-1:0]     t;
  logic [IdxW-1:0]   seg;
  logic [55:0]       step;
  logic [31:0]       mant_q;

  assign yprod = 64'(x_i) * $signed({1'b0, Log2eQ30[30:0]});
  assign t     = TW'(y_q[23:0]) * TW'(EXP_TABLE_ENTRIES);
  assign seg   = t[TW-1:24];
  assign lo_d  = tbl[seg];
  assign hi_d  = tbl[seg + IdxW'(1)];
  assign step  = (hi_q > lo_q) ? 56'(hi_q - lo_q) * 56'(w_q) : 56'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q    <= 32'(yprod >>> 30);
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      w_q    <= t[23:0];
      n1_q   <= y_q[31:24];
      mant_q <= lo_q + step[55:24];
      n2_q   <= n1_q;
    end
  end

  assign valid_o = v_q[2];
  assign mant_o  = mant_q;
  assign exp_o   = n2_q;

endmodule
`default_nettype wire

// File: hw/rtl/monte_carlo_call_payoff_core.sv
`default_nettype none
// -----------------------------------------------------------------------------
// monte_carlo_call_payoff_core
// Discounted European call payoff per Gaussian sample, Black-Scholes path.
// -----------------------------------------------------------------------------
//  channel  dir  handshake      carries
//  req_i    in   valid/ready    gauss_sample, signed Q4.12
//  rsp_o    out  valid/ready    payoff Q16.16, saturated flag
//  apb      in   psel/penable   spot, strike, drift, spread, discount
//
// One request enters per cycle, unless a held response stalls the pipe, and
// passes through nine register stages. All stages advance together; the output
// register decides whether the pipeline may move, so a stalled response holds
// every stage and nothing is lost or repeated. Reset clears valid bits and
// loads register defaults; no clearing pass is needed.
module monte_carlo_call_payoff_core #(
  parameter int unsigned EXP_TABLE_ENTRIES = mcp_pkg::ExpTableEntriesDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  mcp_req_if.sink                          req_i,
  mcp_rsp_if.source                        rsp_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mcp_pkg::AddrW-1:0]   paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import mcp_pkg::*;

  // configuration registers
  logic [31:0] spot_q, strike_q, drift_q, spread_q;
  logic [30:0] disc_q;
  logic        wr_en;
  reg_idx_e    widx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spot_q   <= 32'd6553600;
      strike_q <= 32'd6553600;
      drift_q  <= '0;
      spread_q <= '0;
      disc_q   <= 31'd1073741824;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      case (widx)
        RegSpot:     spot_q   <= pwdata;
        RegStrike:   strike_q <= pwdata;
        RegDrift:    drift_q  <= pwdata;
        RegSpread:   spread_q <= pwdata;
        RegDiscount: disc_q   <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      RegSpot:     prdata = spot_q;
      RegStrike:   prdata = strike_q;
      RegDrift:    prdata = drift_q;
      RegSpread:   prdata = spread_q;
      RegDiscount: prdata = {1'b0, disc_q};
      default:     prdata = '0;
    endcase
  end

  // advance the whole pipe unless a finished response is held
  logic en;
  logic out_valid_q;
  assign en          = !out_valid_q || rsp_o.ready;
  assign req_i.ready = en;

  // stage 1: spread * z
  logic               v1_q, v2_q, v6_q, v7_q, v8_q;
  logic signed [47:0] bz_q;
  // stage 2: x = drift + floor(bz / 2^12), clamped
  logic signed [36:0] xw;
  logic signed [31:0] x_q, x_d;

  assign xw = 37'($signed(drift_q)) + 37'(bz_q >>> 12);
  always_comb begin
    if (xw > 37'sd1073741824) begin
      x_d = 32'(XLimit);
    end else if (xw < -37'sd1073741824) begin
      x_d = -32'(XLimit);
    end else begin
      x_d = xw[31:0];
    end
  end

  // stages 3..5: exponential
  logic              ev;
  logic [31:0]       mant;
  logic signed [7:0] nexp;

  mcp_exp #(.EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)) u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .x_i     (x_q),
    .valid_o (ev),
    .mant_o  (mant),
    .exp_o   (nexp)
  );

  // stage 6: spot * mantissa
  logic [63:0]       p_q;
  logic signed [7:0] n6_q;
  // stage 7: scale by 2^n and clip to 32 bits
  logic [31:0]       price_q, price_d;
  logic              sat7_q, sat7_d;
  logic [63:0]       rsh, hib;
  logic [6:0]        sh;
  logic [5:0]        k;

  always_comb begin
    sh      = '0;
    k       = '0;
    rsh     = '0;
    hib     = '0;
    price_d = '0;
    sat7_d  = 1'b0;
    if (n6_q < 8'sd30) begin
      sh  = 7'(9'sd30 - 9'(n6_q));
      rsh = (sh >= 7'd63) ? 64'd0 : (p_q >> sh);
      if (rsh[63:32] != '0) begin
        price_d = Max32;
        sat7_d  = 1'b1;
      end else begin
        price_d = rsh[31:0];
      end
    end else begin
      k   = 6'(9'(n6_q) - 9'sd30);
      hib = (k >= 6'd33) ? p_q : (p_q >> (6'd32 - k));
      if (p_q == '0) begin
        price_d = '0;
      end else if (k >= 6'd33 || hib != '0) begin
        price_d = Max32;
        sat7_d  = 1'b1;
      end else begin
        price_d = 32'(p_q << k);
      end
    end
  end

  // stage 8: discounted in-the-money amount
  logic [62:0] prod_q;
  logic        sat8_q;
  logic [31:0] diff;
  assign diff = (price_q > strike_q) ? price_q - strike_q : '0;

  // output register
  logic [31:0] pay_q;
  logic        sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      v8_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= req_i.valid;
      v2_q        <= v1_q;
      v6_q        <= ev;
      v7_q        <= v6_q;
      v8_q        <= v7_q;
      out_valid_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bz_q    <= 48'($signed(spread_q)) * 48'(req_i.gauss_sample);
      x_q     <= x_d;
      p_q     <= 64'(spot_q) * 64'(mant);
      n6_q    <= nexp;
      price_q <= price_d;
      sat7_q  <= sat7_d;
      prod_q  <= 63'(diff) * 63'(disc_q);
      sat8_q  <= sat7_q;
      pay_q   <= (prod_q[62:30] > 33'(Max32)) ? Max32 : prod_q[61:30];
      sat_q   <= sat8_q || (prod_q[62:30] > 33'(Max32));
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.payoff    = pay_q;
  assign rsp_o.saturated = sat_q;

  // a held response freezes the last stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v8_q))
    else $error("pipe moved under a held response");

  // an accepted request lands in stage one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && en |=> v1_q)
    else $error("accepted request lost at stage one");

  // an empty last stage never turns into a response
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && !v8_q |=> !out_valid_q)
    else $error("response invented from a bubble");

endmodule
`default_nettype wire

// File: dv/monte_carlo_call_payoff_core_tb.sv
// -----------------------------------------------------------------------------
// monte_carlo_call_payoff_core_tb
// Drives Gaussian samples into the payoff core under several market settings,
// predicts each discounted payoff in fixed point and checks every response in
// order, with random idling on both channels.
// -----------------------------------------------------------------------------
module monte_carlo_call_payoff_core_tb;
  import mcp_pkg::*;

  localparam int unsigned SegCount = ExpTableEntriesDef;
  localparam int unsigned RandomItems = 900;
  localparam int unsigned CycleLimit = 400000;
  localparam longint unsigned AllOnes = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] payoff;
    logic        saturated;
  } payoff_t;

  typedef struct packed {
    logic [31:0] spot;
    logic [31:0] strike;
    logic [31:0] drift;
    logic [31:0] spread;
    logic [31:0] discount;
  } market_t;

  // One directed request: market setting to use, sample, and an optional
  // expectation that can be read straight off the arithmetic.
  typedef struct packed {
    logic [2:0]  market;
    logic [15:0] sample;
    logic        typed;
    payoff_t     want;
  } directed_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  mcp_req_if req_ch ();
  mcp_rsp_if rsp_ch ();

  monte_carlo_call_payoff_core uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor copy of the market registers
  logic [31:0] spot_q, strike_q, drift_q, spread_q, discount_q;
  longint unsigned exp_seg [0:SegCount];

  payoff_t pending_payoffs[$];
  int unsigned mismatches;
  int unsigned cycles;
  bit stim_calm;
  bit drain_calm;

  market_t markets [0:5];
  directed_t directed [$];

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Segment table for 2^f: e^(i*ln2/N) from a truncated series, last entry 2.0
  initial begin
    longint unsigned a, term, sum;
    for (int i = 0; i < SegCount; i++) begin
      a = (longint'(i) * 64'd744261118) / SegCount;
      term = 64'd1073741824;
      sum = term;
      for (int k = 1; k <= 24; k++) begin
        term = ((term * a) >> 30) / k;
        sum += term;
      end
      exp_seg[i] = sum;
    end
    exp_seg[SegCount] = 64'd2147483648;
  end

  function automatic payoff_t call_payoff(logic signed [15:0] z);
    longint x, y, n, s;
    longint unsigned f, t, seg, w, lo, hi, m, p, price, diff, pay;
    payoff_t r;
    r.saturated = 1'b0;
    x = longint'($signed(drift_q)) + ((longint'($signed(spread_q)) * longint'(z)) >>> 12);
    if (x > longint'(XLimit)) x = XLimit;
    if (x < -longint'(XLimit)) x = -longint'(XLimit);
    y = (x * longint'(Log2eQ30)) >>> 30;
    n = y >>> 24;
    f = y & 64'hFF_FFFF;
    t = f * SegCount;
    seg = t >> 24;
    w = t & 64'hFF_FFFF;
    lo = exp_seg[seg];
    hi = exp_seg[seg + 1];
    m = lo + ((hi > lo) ? (((hi - lo) * w) >> 24) : 64'd0);
    p = longint'(spot_q) * m;
    s = 30 - n;
    if (s > 0) begin
      price = (s >= 63) ? 64'd0 : (p >> s);
    end else if (p == 0) begin
      price = 0;
    end else if (-s >= 33 || p > (AllOnes >> -s)) begin
      price = AllOnes + 1;
    end else begin
      price = p << -s;
    end
    // clip the price first; the payoff may clip again above a unit discount
    if (price > AllOnes) begin
      price = AllOnes;
      r.saturated = 1'b1;
    end
    diff = (price > strike_q) ? price - strike_q : 64'd0;
    pay = (diff * longint'(discount_q)) >> 30;
    if (pay > AllOnes) begin
      pay = AllOnes;
      r.saturated = 1'b1;
    end
    r.payoff = pay[31:0];
    return r;
  endfunction

  // Register write: setup cycle, then access cycle; mirror it into the predictor
  task automatic apb_write(logic [AddrW-1:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr[1:0] == 2'b00) begin
      case (reg_idx_e'(addr[4:2]))
        RegSpot:     spot_q = data;
        RegStrike:   strike_q = data;
        RegDrift:    drift_q = data;
        RegSpread:   spread_q = data;
        RegDiscount: discount_q = {1'b0, data[30:0]};
        default: ;
      endcase
    end
  endtask

  // Hold off until every payoff in flight has come back, then let the pipe empty
  task automatic wait_drained();
    while (pending_payoffs.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic load_market(market_t mk);
    wait_drained();
    apb_write({RegSpot, 2'b00}, mk.spot);
    apb_write({RegStrike, 2'b00}, mk.strike);
    apb_write({RegDrift, 2'b00}, mk.drift);
    apb_write({RegSpread, 2'b00}, mk.spread);
    apb_write({RegDiscount, 2'b00}, mk.discount);
  endtask

  // Present one sample after a random gap; valid stays high across back-to-back
  // requests so it never sees two assignments in one step.
  task automatic send_sample(logic [15:0] z, bit typed, payoff_t want);
    int unsigned gap;
    logic rdy;
    gap = stim_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.gauss_sample <= z;
    do begin
      @(negedge clk_i);
      rdy = req_ch.ready;
      @(posedge clk_i);
    end while (!rdy);
    pending_payoffs.push_back(typed ? want : call_payoff(z));
  endtask

  // Response side: stall at random for every response, with calm stretches
  initial begin
    int unsigned gap;
    int unsigned count;
    logic vld;
    rsp_ch.ready = 1'b0;
    count = 0;
    @(posedge rst_ni);
    forever begin
      if (count % 60 == 0) drain_calm = ($urandom_range(0, 3) == 0);
      count++;
      gap = drain_calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do begin
        @(negedge clk_i);
        vld = rsp_ch.valid;
        @(posedge clk_i);
      end while (!vld);
    end
  end

  // Compare every accepted response with the oldest payoff still owed
  always @(posedge clk_i) begin
    payoff_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_payoffs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response payoff=%h saturated=%b", rsp_ch.payoff,
                   rsp_ch.saturated);
      end else begin
        want = pending_payoffs.pop_front();
        if (rsp_ch.payoff !== want.payoff || rsp_ch.saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("payoff mismatch: expected %h/%b, got %h/%b", want.payoff,
                     want.saturated, rsp_ch.payoff, rsp_ch.saturated);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("monte_carlo_call_payoff_core_tb NOT OK");
      $finish;
    end
  end

  function automatic directed_t row(logic [2:0] mk, logic [15:0] z, bit typed,
                                    logic [31:0] pay, logic sat);
    directed_t d;
    d.market = mk;
    d.sample = z;
    d.typed = typed;
    d.want.payoff = pay;
    d.want.saturated = sat;
    return d;
  endfunction

  initial begin
    market_t mk;
    logic [2:0] cur_market;
    logic [15:0] z;
    payoff_t none;
    int unsigned sent;

    none = '0;
    cycles = 0;
    mismatches = 0;
    stim_calm = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.gauss_sample = '0;
    spot_q = 32'd6553600;
    strike_q = 32'd6553600;
    drift_q = 32'd0;
    spread_q = 32'd0;
    discount_q = 32'd1073741824;

    // Market settings for the directed rows
    markets[0] = '{32'd6553600, 32'd6553600, 32'd0, 32'd0, 32'd1073741824};
    // price far above range: clip, zero strike at unit discount
    markets[1] = '{32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1073741824};
    // drift at its most negative: price underflows to zero
    markets[2] = '{32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 32'd0, 32'd1073741824};
    // unit exponent, largest discount register: the payoff overflows
    markets[3] = '{32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF};
    // ordinary market, positive volatility
    markets[4] = '{32'd6553600, 32'd5898240, 32'h0001_0000, 32'h0033_3333, 32'd1020054733};
    // negative spread, zero discount, top strike
    markets[5] = '{32'd13107200, 32'hFFFF_FFFF, 32'hFFF0_0000, 32'h8000_0000, 32'd0};

    // At reset the exponent is zero, so price equals spot equals strike
    directed.push_back(row(0, 16'h0000, 1, 32'd0, 1'b0));
    directed.push_back(row(0, 16'h7FFF, 1, 32'd0, 1'b0));
    directed.push_back(row(0, 16'h8000, 1, 32'd0, 1'b0));
    directed.push_back(row(1, 16'h7FFF, 1, 32'hFFFF_FFFF, 1'b1));
    directed.push_back(row(1, 16'h0001, 1, 32'hFFFF_FFFF, 1'b1));
    directed.push_back(row(1, 16'h8000, 0, 32'd0, 1'b0));
    directed.push_back(row(1, 16'hFFFF, 0, 32'd0, 1'b0));
    directed.push_back(row(2, 16'h0000, 1, 32'd0, 1'b0));
    directed.push_back(row(2, 16'h5555, 1, 32'd0, 1'b0));
    directed.push_back(row(3, 16'h0000, 1, 32'hFFFF_FFFF, 1'b1));
    directed.push_back(row(3, 16'hAAAA, 1, 32'hFFFF_FFFF, 1'b1));
    directed.push_back(row(4, 16'h0000, 0, 32'd0, 1'b0));
    directed.push_back(row(4, 16'h1000, 0, 32'd0, 1'b0));
    directed.push_back(row(4, 16'hF000, 0, 32'd0, 1'b0));
    directed.push_back(row(4, 16'h7FFF, 0, 32'd0, 1'b0));
    directed.push_back(row(4, 16'h8000, 0, 32'd0, 1'b0));
    directed.push_back(row(4, 16'h5555, 0, 32'd0, 1'b0));
    directed.push_back(row(4, 16'hAAAA, 0, 32'd0, 1'b0));
    // price clips at the top, zero discount still flags the clip
    directed.push_back(row(5, 16'h8000, 1, 32'd0, 1'b1));
    directed.push_back(row(5, 16'h7FFF, 1, 32'd0, 1'b0));
    directed.push_back(row(5, 16'h0000, 1, 32'd0, 1'b0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A write to an unmapped address must leave every register untouched
    apb_write(5'd20, 32'hDEAD_BEEF);

    cur_market = 0;
    foreach (directed[i]) begin
      if (directed[i].market != cur_market) begin
        req_ch.valid <= 1'b0;
        load_market(markets[directed[i].market]);
        cur_market = directed[i].market;
      end
      send_sample(directed[i].sample, directed[i].typed, directed[i].want);
    end

    // Random markets, each followed by a burst of samples
    sent = 0;
    while (sent < RandomItems) begin
      req_ch.valid <= 1'b0;
      case ($urandom_range(0, 3))
        0: begin
          mk.spot = $urandom;
          mk.strike = $urandom;
          mk.drift = $urandom;
          mk.spread = $urandom;
          mk.discount = $urandom_range(0, 32'h7FFF_FFFF);
        end
        default: begin
          // realistic: prices from 1 to 512, modest drift and vol
          mk.spot = $urandom_range(32'h0001_0000, 32'h0200_0000);
          mk.strike = mk.spot + $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
          mk.drift = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
          mk.spread = $urandom_range(0, 32'h0100_0000);
          mk.discount = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32'h7FFF_FFFF)
                                                    : $urandom_range(32'h3800_0000,
                                                                     32'h4000_0000);
        end
      endcase
      load_market(mk);
      stim_calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 100 && sent < RandomItems; i++) begin
        if (i == 50) begin
          // hold until every payoff has been returned
          req_ch.valid <= 1'b0;
          while (pending_payoffs.size() != 0) @(posedge clk_i);
        end
        z = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                        : 16'($urandom_range(0, 16'h6000) - 16'h3000);
        send_sample(z, 1'b0, none);
        sent++;
      end
    end
    req_ch.valid <= 1'b0;

    while (pending_payoffs.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("monte_carlo_call_payoff_core_tb OK");
    end else begin
      $display("monte_carlo_call_payoff_core_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/mcp_pkg.sv
hw/rtl/mcp_if.sv
hw/rtl/mcp_exp.sv
hw/rtl/monte_carlo_call_payoff_core.sv
dv/monte_carlo_call_payoff_core_tb.sv
